FILE: sv/lubm_pkg.sv
// ----------------------------------------------------------------------------
// lubm_pkg - linked unit buffer manager shared types
// Item layouts, operation and status codes, byte mask helper.
// ----------------------------------------------------------------------------
package lubm_pkg;

   localparam int HandleWidth = 11;
   localparam int DataWidth   = 64;
   localparam int UnitBytes   = 8;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_FREE  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_UNITS = 2'd1;
   localparam logic [1:0] STATUS_BROKEN   = 2'd2;
   localparam logic [1:0] STATUS_SMALL    = 2'd3;

   typedef struct packed {
      logic [1:0]             func;
      logic [HandleWidth-1:0] handle;
      logic [7:0]             length;
      logic [DataWidth-1:0]   payload;
      logic [3:0]             payload_bytes;
      logic [6:0]             skip;
      logic [7:0]             capacity;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HandleWidth-1:0] handle_out;
      logic [DataWidth-1:0]   chunk;
      logic [3:0]             chunk_bytes;
      logic [7:0]             total_bytes;
      logic                   last;
   } rsp_type;

   // low n bytes set, all bytes for n of 8 or more
   function automatic logic [DataWidth-1:0] byte_mask(input logic [3:0] n);
      logic [DataWidth-1:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < n) m[8*b +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

FILE: sv/lubm_if.sv
// ----------------------------------------------------------------------------
// lubm_if - request and response channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface lubm_req_if;
   import lubm_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lubm_rsp_if;
   import lubm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/linked_unit_buffer_manager_top.sv
// ----------------------------------------------------------------------------
// linked_unit_buffer_manager_top - pooled unit chains with a free list
// Alloc walks the free list unit by unit, write updates one unit, read walks the chain
// (with an error item for a too-small buffer after a chunk), free walks the chain to its
// tail; each result then waits for its handshake and any output stall.
// Throughput: one item at a time; every link walked costs one next_link read.
// Reset: clears control, then sweeps next_link over units 0 to POOL_UNITS.
// ----------------------------------------------------------------------------
module linked_unit_buffer_manager_top #(
   parameter int POOL_UNITS = 1024,
   parameter int MAX_CHAIN  = 16
) (
   input logic        clock,
   input logic        reset,
   lubm_req_if.sink   req_ch,
   lubm_rsp_if.source rsp_ch
);
   import lubm_pkg::*;

   // address/link width, chain counter width, free count width
   localparam int AW = $clog2(POOL_UNITS + 1);
   localparam int CW = $clog2(MAX_CHAIN + 1);
   localparam int NW = $clog2(POOL_UNITS + 1);

   // sequencer states
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_ALOC_CHK = 4'd2;
   localparam logic [3:0] S_ALOC_TST = 4'd3;
   localparam logic [3:0] S_ALOC_USE = 4'd4;
   localparam logic [3:0] S_WR_CHK   = 4'd5;
   localparam logic [3:0] S_WR_USE   = 4'd6;
   localparam logic [3:0] S_RD_TST   = 4'd7;
   localparam logic [3:0] S_RD_USE   = 4'd8;
   localparam logic [3:0] S_RD_ERR   = 4'd9;
   localparam logic [3:0] S_FR_RD    = 4'd10;
   localparam logic [3:0] S_FR_USE   = 4'd11;
   localparam logic [3:0] S_SEND     = 4'd12;

   function automatic logic is_unit(input logic [31:0] h);
      return (h >= 32'd1) && (h <= 32'(POOL_UNITS));
   endfunction

   // pool storage; index 0 is the null unit
   logic [AW-1:0]        next_link [0:POOL_UNITS];
   logic [3:0]           unit_fill [0:POOL_UNITS];
   logic [DataWidth-1:0] unit_data [0:POOL_UNITS];

   logic [AW-1:0]        link_rd_ff;
   logic [3:0]           fill_rd_ff;
   logic [DataWidth-1:0] data_rd_ff;

   // memory port controls
   logic                 link_we;
   logic [AW-1:0]        link_wa;
   logic [AW-1:0]        link_wd;
   logic                 unit_we;
   logic [3:0]           fill_wd;
   logic [DataWidth-1:0] data_wd;

   // sequencer registers
   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;
   logic [AW-1:0] clr_ff, clr_in;
   req_type       op_ff, op_in;
   logic [AW-1:0] u_ff, u_in;          // current unit, also the read address
   logic [AW-1:0] tail_ff, tail_in;    // alloc tail, free chain head
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] free_head_ff, free_head_in;
   logic [NW-1:0] free_count_ff, free_count_in;
   logic [6:0]    skip_ff, skip_in;
   logic [7:0]    cap_ff, cap_in;
   logic [7:0]    total_ff, total_in;
   rsp_type       pend_ff, pend_in;    // chunk held until we know if it is last
   logic          pend_vld_ff, pend_vld_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_vld_ff, rsp_vld_in;

   // alloc unit count, division by a power-of-two constant
   logic [8:0] units;
   assign units = ((9'(op_ff.length) + 9'(UnitBytes - 1)) / 9'(UnitBytes) == 9'd0)
                  ? 9'd1
                  : (9'(op_ff.length) + 9'(UnitBytes - 1)) / 9'(UnitBytes);

   // read chunk for the unit just fetched
   logic [3:0]           keep;
   logic [DataWidth-1:0] chunk_val;
   assign keep = fill_rd_ff - skip_ff[3:0];

   lubm_chunk u_chunk (
      .unit_data  (data_rd_ff),
      .skip_bytes (skip_ff[3:0]),
      .keep_bytes (keep),
      .chunk      (chunk_val)
   );

   logic [NW:0] count_sum;
   assign count_sum = (NW+1)'(free_count_ff) + (NW+1)'(cnt_ff);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_vld_ff;
   assign rsp_ch.data  = rsp_ff;

   always_comb begin
      rsp_type r;
      state_in      = state_ff;
      ret_in        = ret_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      u_in          = u_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      skip_in       = skip_ff;
      cap_in        = cap_ff;
      total_in      = total_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      rsp_in        = rsp_ff;
      rsp_vld_in    = rsp_vld_ff;
      link_we       = 1'b0;
      link_wa       = u_ff;
      link_wd       = '0;
      unit_we       = 1'b0;
      fill_wd       = (op_ff.payload_bytes > 4'(UnitBytes)) ? 4'(UnitBytes)
                                                            : op_ff.payload_bytes;
      data_wd       = op_ff.payload & byte_mask(fill_wd);
      r             = '0;
      r.last        = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            // reset sweep: unit i links to i+1, last unit and null to 0
            link_we = 1'b1;
            link_wa = clr_ff;
            link_wd = (clr_ff == '0 || clr_ff == AW'(POOL_UNITS)) ? '0 : clr_ff + 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(POOL_UNITS)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in       = req_ch.data;
               u_in        = is_unit(32'(req_ch.data.handle)) ? AW'(req_ch.data.handle) : '0;
               tail_in     = AW'(req_ch.data.handle);
               skip_in     = req_ch.data.skip;
               cap_in      = req_ch.data.capacity;
               total_in    = '0;
               pend_vld_in = 1'b0;
               cnt_in      = '0;
               ret_in      = S_IDLE;
               case (req_ch.data.func)
                  FUNC_ALLOC: state_in = S_ALOC_CHK;
                  FUNC_WRITE: state_in = S_WR_CHK;
                  FUNC_READ:  state_in = S_RD_TST;
                  FUNC_FREE: begin
                     cnt_in   = CW'(1);
                     state_in = S_FR_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ALOC_CHK: begin
            if (32'(units) > 32'(free_count_ff) || 32'(units) > 32'(MAX_CHAIN)) begin
               r.status   = STATUS_NO_UNITS;
               rsp_in     = r;
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               u_in     = free_head_ff;
               state_in = S_ALOC_TST;
            end
         end
         S_ALOC_TST: begin
            if (32'(cnt_ff) == 32'(units)) begin
               // commit: cut the chain and advance the free list
               link_we       = 1'b1;
               link_wa       = tail_ff;
               link_wd       = '0;
               free_head_in  = is_unit(32'(u_ff)) ? u_ff : '0;
               free_count_in = free_count_ff - NW'(units);
               r.handle_out  = HandleWidth'(free_head_ff);
               rsp_in        = r;
               rsp_vld_in    = 1'b1;
               state_in      = S_SEND;
            end else if (!is_unit(32'(u_ff))) begin
               r.status   = STATUS_BROKEN;
               rsp_in     = r;
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               tail_in  = u_ff;           // next_link[u] read issued here
               state_in = S_ALOC_USE;
            end
         end
         S_ALOC_USE: begin
            u_in     = link_rd_ff;
            cnt_in   = cnt_ff + 1'b1;
            state_in = S_ALOC_TST;
         end
         S_WR_CHK: begin
            if (u_ff == '0) begin
               rsp_in     = r;
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               unit_we  = 1'b1;
               state_in = S_WR_USE;
            end
         end
         S_WR_USE: begin
            r.handle_out = HandleWidth'(link_rd_ff);
            rsp_in       = r;
            rsp_vld_in   = 1'b1;
            state_in     = S_SEND;
         end
         S_RD_TST: begin
            if (32'(cnt_ff) < 32'(MAX_CHAIN) && is_unit(32'(u_ff))) begin
               state_in = S_RD_USE;
            end else begin
               // end of walk: held chunk is the last, else one empty item
               if (pend_vld_ff) begin
                  r      = pend_ff;
                  r.last = 1'b1;
               end else begin
                  r.total_bytes = total_ff;
               end
               rsp_in      = r;
               rsp_vld_in  = 1'b1;
               pend_vld_in = 1'b0;
               ret_in      = S_IDLE;
               state_in    = S_SEND;
            end
         end
         S_RD_USE: begin
            u_in   = link_rd_ff;
            cnt_in = cnt_ff + 1'b1;
            if (skip_ff >= 7'(fill_rd_ff)) begin
               skip_in  = skip_ff - 7'(fill_rd_ff);
               state_in = S_RD_TST;
            end else if (cap_ff < 8'(fill_rd_ff)) begin
               if (pend_vld_ff) begin
                  rsp_in      = pend_ff;
                  pend_vld_in = 1'b0;
                  ret_in      = S_RD_ERR;
               end else begin
                  r.status      = STATUS_SMALL;
                  r.total_bytes = total_ff;
                  rsp_in        = r;
                  ret_in        = S_IDLE;
               end
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               r.chunk       = chunk_val;
               r.chunk_bytes = keep;
               r.total_bytes = total_ff + 8'(keep);
               r.last        = 1'b0;
               total_in      = total_ff + 8'(keep);
               cap_in        = cap_ff - 8'(keep);
               skip_in       = '0;
               pend_in       = r;
               pend_vld_in   = 1'b1;
               if (pend_vld_ff) begin
                  rsp_in     = pend_ff;
                  rsp_vld_in = 1'b1;
                  ret_in     = S_RD_TST;
                  state_in   = S_SEND;
               end else begin
                  state_in = S_RD_TST;
               end
            end
         end
         S_RD_ERR: begin
            r.status      = STATUS_SMALL;
            r.total_bytes = total_ff;
            rsp_in        = r;
            rsp_vld_in    = 1'b1;
            ret_in        = S_IDLE;
            state_in      = S_SEND;
         end
         S_FR_RD: begin
            if (u_ff == '0) begin
               rsp_in     = r;
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               state_in = S_FR_USE;
            end
         end
         S_FR_USE: begin
            if (!is_unit(32'(link_rd_ff))) begin
               // chain tail found: splice onto the free list
               link_we       = 1'b1;
               link_wa       = u_ff;
               link_wd       = free_head_ff;
               free_head_in  = tail_ff;
               free_count_in = (count_sum > (NW+1)'(POOL_UNITS)) ? NW'(POOL_UNITS)
                                                                : count_sum[NW-1:0];
               rsp_in        = r;
               rsp_vld_in    = 1'b1;
               state_in      = S_SEND;
            end else if (32'(cnt_ff) >= 32'(MAX_CHAIN)) begin
               r.status   = STATUS_BROKEN;
               rsp_in     = r;
               rsp_vld_in = 1'b1;
               state_in   = S_SEND;
            end else begin
               u_in     = link_rd_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_FR_RD;
            end
         end
         S_SEND: begin
            if (rsp_ch.ready) begin
               rsp_vld_in = 1'b0;
               state_in   = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ret_ff        <= S_IDLE;
         clr_ff        <= '0;
         free_head_ff  <= AW'(1);
         free_count_ff <= NW'(POOL_UNITS);
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      u_ff     <= u_in;
      tail_ff  <= tail_in;
      cnt_ff   <= cnt_in;
      skip_ff  <= skip_in;
      cap_ff   <= cap_in;
      total_ff <= total_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   // pool memories, one registered read at u_ff
   always_ff @(posedge clock) begin
      if (link_we) next_link[link_wa] <= link_wd;
      if (unit_we) begin
         unit_fill[u_ff] <= fill_wd;
         unit_data[u_ff] <= data_wd;
      end
      link_rd_ff <= next_link[u_ff];
      fill_rd_ff <= unit_fill[u_ff];
      data_rd_ff <= unit_data[u_ff];
   end

endmodule

FILE: sv/lubm_chunk.sv
// ----------------------------------------------------------------------------
// lubm_chunk - read chunk extraction
// Drops skipped bytes and masks the chunk to its byte count.
// ----------------------------------------------------------------------------
module lubm_chunk (
   input  logic [lubm_pkg::DataWidth-1:0] unit_data,
   input  logic [3:0]                     skip_bytes,
   input  logic [3:0]                     keep_bytes,
   output logic [lubm_pkg::DataWidth-1:0] chunk
);
   import lubm_pkg::*;

   logic [DataWidth-1:0] shifted;

   assign shifted = unit_data >> {skip_bytes, 3'b000};
   assign chunk   = shifted & byte_mask(keep_bytes);

endmodule

FILE: dv/lubm_checker.sv
// ----------------------------------------------------------------------------
// lubm_checker - result checker for the linked unit buffer manager
// Watches both channels, predicts the result items of each accepted request
// from its own copy of the pool and free list, and compares field by field.
// ----------------------------------------------------------------------------
module lubm_checker #(
   parameter int POOL_UNITS = 1024,
   parameter int UNIT_BYTES = 8,
   parameter int MAX_CHAIN  = 16
) (
   input  logic clock,
   input  logic reset,
   lubm_req_if  req_ch,
   lubm_rsp_if  rsp_ch,
   output int   errors,
   output int   pending
);
   import lubm_pkg::*;

   logic [HandleWidth-1:0] link_mem [0:POOL_UNITS];
   logic [3:0]             fill_mem [0:POOL_UNITS];
   logic [DataWidth-1:0]   data_mem [0:POOL_UNITS];
   int                     free_head;
   int                     free_count;
   rsp_type                expected_q [$];

   function automatic bit unit_ok(input int h);
      return h >= 1 && h <= POOL_UNITS;
   endfunction

   function automatic logic [DataWidth-1:0] low_bytes(input int n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic predict_item(input req_type r);
      rsp_type e;
      int units, u, tail, total, skp, cap, f, c, i, n, h;
      bit stop;
      logic [DataWidth-1:0] d;
      e = '0;
      e.last = 1'b1;
      h = int'(r.handle);
      stop = 0;
      case (r.func)
         FUNC_ALLOC: begin
            units = (int'(r.length) + UNIT_BYTES - 1) / UNIT_BYTES;
            if (units == 0) units = 1;
            if (units > free_count || units > MAX_CHAIN) begin
               e.status = STATUS_NO_UNITS;
            end else begin
               u = free_head;
               tail = 0;
               for (i = 0; i < units; i++) begin
                  if (!unit_ok(u)) begin
                     stop = 1;
                     break;
                  end
                  tail = u;
                  u = int'(link_mem[u]);
               end
               if (stop) begin
                  e.status = STATUS_BROKEN;
               end else begin
                  e.handle_out = HandleWidth'(free_head);
                  link_mem[tail] = '0;
                  free_head = unit_ok(u) ? u : 0;
                  free_count -= units;
               end
            end
            expected_q.push_back(e);
         end
         FUNC_WRITE: begin
            if (unit_ok(h)) begin
               f = (r.payload_bytes > UNIT_BYTES) ? UNIT_BYTES : int'(r.payload_bytes);
               fill_mem[h] = 4'(f);
               data_mem[h] = r.payload & low_bytes(f);
               e.handle_out = link_mem[h];
            end
            expected_q.push_back(e);
         end
         FUNC_READ: begin
            total = 0;
            n = 0;
            u = h;
            skp = int'(r.skip);
            cap = int'(r.capacity);
            for (i = 0; i < MAX_CHAIN && unit_ok(u); i++) begin
               f = int'(fill_mem[u]);
               d = data_mem[u];
               u = int'(link_mem[u]);
               if (skp >= f) begin
                  skp -= f;
                  continue;
               end
               if (cap < f) begin
                  // buffer too small: error item closes the read
                  e = '0;
                  e.status = STATUS_SMALL;
                  e.total_bytes = 8'(total);
                  e.last = 1'b1;
                  expected_q.push_back(e);
                  stop = 1;
                  break;
               end
               c = f - skp;
               total += c;
               cap -= c;
               e = '0;
               e.chunk = (d >> (8 * skp)) & low_bytes(c);
               e.chunk_bytes = 4'(c);
               e.total_bytes = 8'(total);
               expected_q.push_back(e);
               n++;
               skp = 0;
            end
            if (!stop) begin
               if (n == 0) begin
                  e = '0;
                  e.last = 1'b1;
                  e.total_bytes = 8'(total);
                  expected_q.push_back(e);
               end else begin
                  expected_q[expected_q.size() - 1].last = 1'b1;
               end
            end
         end
         default: begin
            if (unit_ok(h)) begin
               u = h;
               i = 1;
               forever begin
                  if (!unit_ok(int'(link_mem[u]))) break;
                  if (i >= MAX_CHAIN) begin
                     stop = 1;
                     break;
                  end
                  u = int'(link_mem[u]);
                  i++;
               end
               if (stop) begin
                  e.status = STATUS_BROKEN;
               end else begin
                  link_mem[u] = HandleWidth'(free_head);
                  free_head = h;
                  free_count += i;
                  if (free_count > POOL_UNITS) free_count = POOL_UNITS;
               end
            end
            expected_q.push_back(e);
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i <= POOL_UNITS; i++) begin
            link_mem[i] = (i >= 1 && i < POOL_UNITS) ? HandleWidth'(i + 1) : '0;
            fill_mem[i] = '0;
            data_mem[i] = '0;
         end
         free_head = 1;
         free_count = POOL_UNITS;
         expected_q.delete();
         errors = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_item(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (expected_q.size() == 0) begin
               report("unexpected item", 64'(got.handle_out), 64'd0);
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status)
                  report("status", 64'(got.status), 64'(want.status));
               if (got.handle_out != want.handle_out)
                  report("handle_out", 64'(got.handle_out), 64'(want.handle_out));
               if (got.chunk != want.chunk) report("chunk", got.chunk, want.chunk);
               if (got.chunk_bytes != want.chunk_bytes)
                  report("chunk_bytes", 64'(got.chunk_bytes), 64'(want.chunk_bytes));
               if (got.total_bytes != want.total_bytes)
                  report("total_bytes", 64'(got.total_bytes), 64'(want.total_bytes));
               if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: dv/linked_unit_buffer_manager_top_test.sv
// ----------------------------------------------------------------------------
// linked_unit_buffer_manager_top_test - testbench top for the buffer manager
// Builds chains by alloc plus a write walk, then mixes reads, rewrites, frees
// and malformed requests under bursty input and stalling output. The checker
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module linked_unit_buffer_manager_top_test;
   import lubm_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int RandomItems = 170;

   logic clock;
   logic reset;
   int   errors;
   int   pending;

   lubm_req_if req_if ();
   lubm_rsp_if rsp_if ();

   linked_unit_buffer_manager_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   lubm_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .errors  (errors),
      .pending (pending)
   );

   // bookkeeping for stimulus: ops issued vs ops closed (last item seen)
   int                     ops_sent;
   int                     ops_done;
   logic [HandleWidth-1:0] last_handle;
   logic [1:0]             last_status;
   int                     items_sent;
   int                     burst_left;
   int                     hold_asks;
   int                     cycles;
   // heads of chains that are allocated and fully written
   int                     live_heads [$];

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result tap: alloc head and write next link come back here
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready && rsp_if.data.last) begin
         ops_done    <= ops_done + 1;
         last_handle <= rsp_if.data.handle_out;
         last_status <= rsp_if.data.status;
      end
   end

   // receiver: stall mode changes now and then; a hold request blocks for long
   initial begin
      int mode;
      int mode_left;
      int hold_seen;
      int hold_left;
      mode = 0;
      mode_left = 0;
      hold_seen = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(0, 1));
               default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // random filler for fields the operation ignores
   function automatic req_type rand_item(input logic [1:0] func, input int handle);
      req_type r;
      r.func          = func;
      r.handle        = HandleWidth'(handle);
      r.length        = 8'($urandom_range(0, 128));
      r.payload       = {$urandom, $urandom};
      r.payload_bytes = 4'($urandom_range(0, 15));
      r.skip          = 7'($urandom_range(0, 127));
      r.capacity      = 8'($urandom_range(0, 128));
      return r;
   endfunction

   // sender: bursts of random length with random gaps in between
   task automatic send_item(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      forever begin
         @(negedge clock);
         if (req_if.ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      ops_sent++;
      items_sent++;
   endtask

   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (ops_done != ops_sent) @(posedge clock);
   endtask

   // alloc, then write every unit along the new chain, following next links
   task automatic build_chain(input int length);
      req_type r;
      int head;
      int cur;
      int count;
      wait_quiet();
      r = rand_item(FUNC_ALLOC, $urandom_range(0, 2047));
      r.length = 8'(length);
      send_item(r);
      wait_quiet();
      head = int'(last_handle);
      if (last_status != STATUS_OK || head == 0) return;
      cur = head;
      count = 0;
      while (cur != 0 && count < 16) begin
         r = rand_item(FUNC_WRITE, cur);
         send_item(r);
         wait_quiet();
         cur = int'(last_handle);
         count++;
      end
      live_heads.push_back(head);
   endtask

   task automatic read_chain(input int handle, input int skip, input int capacity);
      req_type r;
      r = rand_item(FUNC_READ, handle);
      r.skip = 7'(skip);
      r.capacity = 8'(capacity);
      send_item(r);
   endtask

   function automatic int pick_live();
      if (live_heads.size() == 0) return 0;
      return live_heads[$urandom_range(0, live_heads.size() - 1)];
   endfunction

   // free a live chain; optionally free it again, which walks into the free
   // list and must come back as broken with no change
   task automatic free_chain(input bit twice);
      int idx;
      if (live_heads.size() == 0) return;
      idx = $urandom_range(0, live_heads.size() - 1);
      send_item(rand_item(FUNC_FREE, live_heads[idx]));
      if (twice) send_item(rand_item(FUNC_FREE, live_heads[idx]));
      live_heads.delete(idx);
   endtask

   initial begin
      req_type r;
      int sel;
      bit held;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      ops_sent = 0;
      ops_done = 0;
      last_handle = '0;
      last_status = '0;
      items_sent = 0;
      burst_left = 0;
      hold_asks = 0;
      cycles = 0;
      held = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: length extremes, unit boundary, the longest chain
      build_chain(0);
      build_chain(8);
      build_chain(9);
      build_chain(128);
      // payload extremes on a live head, fill saturating at 8 and empty fill
      r = rand_item(FUNC_WRITE, live_heads[1]);
      r.payload = '1;
      r.payload_bytes = 4'd15;
      send_item(r);
      r = rand_item(FUNC_WRITE, live_heads[2]);
      r.payload = '0;
      r.payload_bytes = 4'd0;
      send_item(r);
      read_chain(live_heads[3], 0, 128);
      read_chain(live_heads[1], 0, 8);
      read_chain(live_heads[3], 127, 128);   // largest skip
      read_chain(live_heads[3], 3, 0);       // no room at all
      read_chain(live_heads[2], 5, 128);
      // null and out of range handles
      read_chain(0, 0, 128);
      read_chain(2047, 0, 128);
      send_item(rand_item(FUNC_WRITE, 0));
      send_item(rand_item(FUNC_WRITE, 1025));
      send_item(rand_item(FUNC_FREE, 0));
      send_item(rand_item(FUNC_FREE, 2047));
      send_item(rand_item(FUNC_WRITE, 1024));  // top unit, still free
      free_chain(1'b1);

      // random mix, mostly well formed chains with random content
      while (items_sent < RandomItems) begin
         if (!held && items_sent > 110) begin
            // long receiver hold while the sender keeps offering reads
            held = 1;
            wait_quiet();
            hold_asks++;
            repeat (12) read_chain(pick_live(), $urandom_range(0, 20), $urandom_range(0, 128));
         end
         sel = $urandom_range(0, 99);
         if (sel < 15 || live_heads.size() == 0) begin
            build_chain(($urandom_range(0, 9) == 0) ? $urandom_range(0, 128)
                                                    : $urandom_range(0, 40));
         end else if (sel < 50) begin
            read_chain(pick_live(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                               : $urandom_range(0, 12),
                       $urandom_range(0, 128));
         end else if (sel < 65) begin
            send_item(rand_item(FUNC_WRITE, $urandom_range(1, 1024)));
         end else if (sel < 75) begin
            if (live_heads.size() > 2) free_chain($urandom_range(0, 3) == 0);
         end else if (sel < 85) begin
            send_item(rand_item(2'($urandom_range(1, 3)), $urandom_range(1025, 2047)));
         end else begin
            send_item(rand_item(2'($urandom_range(1, 3)), 0));
         end
      end

      wait_quiet();
      repeat (60) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
